// ===== design/pjt_pkg.sv =====
// Shared types and codes for the periodic job timer table.
package pjt_pkg;

    localparam int NUM_JOBS_DEF = 16;

    // request actions
    localparam logic [2:0] ACT_TICK     = 3'd0;
    localparam logic [2:0] ACT_CREATE   = 3'd1;
    localparam logic [2:0] ACT_SET_ST   = 3'd2;
    localparam logic [2:0] ACT_SET_IVL  = 3'd3;
    localparam logic [2:0] ACT_SET_ITER = 3'd4;
    localparam logic [2:0] ACT_REMOVE   = 3'd5;
    localparam logic [2:0] ACT_QUERY    = 3'd6;
    localparam logic [2:0] ACT_NOP      = 3'd7;

    // result kinds
    localparam logic [2:0] KIND_FIRED   = 3'd0;
    localparam logic [2:0] KIND_REMOVED = 3'd1;
    localparam logic [2:0] KIND_WAKE    = 3'd2;
    localparam logic [2:0] KIND_REPLY   = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;

    // job status
    localparam logic [1:0] ST_SUSP = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_EXP  = 2'd2;
    localparam logic [1:0] ST_ALT  = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] time_left;
        logic [30:0]        period;
        logic [30:0]        runs_left;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [2:0]         kind;
        logic [3:0]         job_slot;
        logic signed [31:0] remaining_ms;
        logic [1:0]         job_status;
        logic [30:0]        iterations_left;
        logic               expired_now;
        logic               wake_valid;
        logic [1:0]         error_code;
        logic               last;
    } result_t;

endpackage

// ===== design/pjt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pjt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/pjt_out_reg.sv =====
// Output result register: holds one result until the receiver takes it.
module pjt_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pjt_pkg::result_t res,
    input  logic             out_stall,
    output logic             out_valid,
    output logic             free,
    output pjt_pkg::result_t res_out
);

    logic             valid_reg;
    logic             valid_next;
    pjt_pkg::result_t res_reg;

    // slot is free when empty or being drained this cycle
    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> free)
        else $error("result pushed over an untaken result");

    a_wake_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && res_reg.kind == pjt_pkg::KIND_WAKE) |-> res_reg.last)
        else $error("wake result not marked last");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_stall) |=> (valid_reg && $stable(res_reg)))
        else $error("stalled result changed");

endmodule

// ===== design/periodic_job_timer_table.sv =====
// Top level of the periodic job timer table: control sequencer around the job RAM.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request: a tick, a create,
//   a set of status, interval or iterations, a remove or a query. Output channel
//   (out_valid / out_stall) carries result items; the final one of a request has
//   last set. Action 7 is taken and dropped with no result.
//   All job fields live in one RAM (status, remaining time, period, iterations),
//   one entry per slot; only the slot-used bits are flip-flops.
//   Tick: the sequencer walks every slot (RAM read, then saturating subtract,
//   then fire decision and write-back while the next slot is read), and then
//   emits the next-wake result.
//   Single-slot requests do a RAM read, then update and reply.
//   Results pass through a one-deep output register, so a new request is taken
//   while the last result still waits. A stall holds the sequencer at the step
//   that needs to emit; nothing is lost or repeated.
//   Reset clears all slot-used bits at once and empties the output register;
//   RAM contents are written by create before they are used.
module periodic_job_timer_table #(
    parameter int NUM_JOBS = pjt_pkg::NUM_JOBS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         action,
    input  logic [3:0]         slot,
    input  logic [30:0]        delta_ms,
    input  logic [30:0]        interval_ms,
    input  logic [30:0]        iteration_count,
    input  logic [1:0]         new_status,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         kind,
    output logic [3:0]         job_slot,
    output logic signed [31:0] remaining_ms,
    output logic [1:0]         job_status,
    output logic [30:0]        iterations_left,
    output logic               expired_now,
    output logic               wake_valid,
    output logic [1:0]         error_code,
    output logic               last
);

    localparam int AW = (NUM_JOBS > 1) ? $clog2(NUM_JOBS) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_JOBS - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ONE  = 5'b00010,
        S_SUB  = 5'b00100,
        S_UPD  = 5'b01000,
        S_WAKE = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic [NUM_JOBS-1:0]    used_reg, used_next;
    logic                   have_reg, have_next;
    logic [31:0]            best_reg, best_next;
    logic signed [31:0]     t_reg, t_next;
    pjt_pkg::entry_t        ent_reg, ent_next;

    // latched request
    logic [2:0]             act_reg;
    logic [3:0]             slot_reg;
    logic [30:0]            delta_reg;
    logic [30:0]            ivl_reg;
    logic [30:0]            cnt_reg;
    logic [1:0]             ns_reg;

    // RAM port signals
    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    pjt_pkg::entry_t        ram_wdata, rd_ent;
    logic [pjt_pkg::ENTRY_W-1:0] ram_rdata;

    // output register
    logic                   push, out_free;
    pjt_pkg::result_t       res, res_q;

    logic                   accept;
    logic [AW-1:0]          free_idx;
    logic                   free_found;
    logic [AW-1:0]          sidx;
    logic                   slot_ok;
    logic signed [32:0]     diff;
    logic signed [31:0]     sat_t;
    logic [30:0]            runs_dec;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign rd_ent   = pjt_pkg::entry_t'(ram_rdata);
    assign sidx     = AW'(slot_reg);
    assign slot_ok  = (32'(slot_reg) < 32'(NUM_JOBS)) && used_reg[sidx];

    // lowest free slot
    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = NUM_JOBS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx   = AW'(i);
                free_found = 1'b1;
            end
        end
    end

    // saturating subtract of the elapsed time; suspended jobs keep their time
    assign diff  = {rd_ent.time_left[31], rd_ent.time_left} - {2'b00, delta_reg};
    assign sat_t = (rd_ent.status == pjt_pkg::ST_SUSP) ? rd_ent.time_left :
                   (diff[32] != diff[31]) ? 32'sh8000_0000 : diff[31:0];

    assign runs_dec = (ent_reg.runs_left != '0) ? ent_reg.runs_left - 31'd1
                                                : ent_reg.runs_left;

    always_comb
    begin
        logic             fire;
        logic             gone;
        logic             emit;
        logic             cand;
        logic [31:0]      cand_v;
        pjt_pkg::entry_t  upd;

        state_next = state_reg;
        idx_next   = idx_reg;
        used_next  = used_reg;
        have_next  = have_reg;
        best_next  = best_reg;
        t_next     = t_reg;
        ent_next   = ent_reg;
        ram_re     = 1'b0;
        ram_raddr  = idx_reg;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = ent_reg;
        push       = 1'b0;
        res        = '0;
        fire       = 1'b0;
        gone       = 1'b0;
        emit       = 1'b0;
        cand       = 1'b0;
        cand_v     = '0;
        upd        = ent_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (action == pjt_pkg::ACT_TICK)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        idx_next   = '0;
                        have_next  = 1'b0;
                        best_next  = '0;
                        state_next = S_SUB;
                    end
                    else if (action != pjt_pkg::ACT_NOP)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = AW'(slot);
                        state_next = S_ONE;
                    end
                end
            end

            S_SUB:
            begin
                ent_next   = rd_ent;
                t_next     = sat_t;
                state_next = S_UPD;
            end

            S_UPD:
            begin
                upd.time_left = t_reg;
                if (used_reg[idx_reg])
                begin
                    if (ent_reg.status == pjt_pkg::ST_WAIT &&
                        (t_reg[31] || t_reg == '0))
                    begin
                        fire           = 1'b1;
                        gone           = (ent_reg.runs_left == 31'd1);
                        upd.time_left  = {1'b0, ent_reg.period};
                        upd.runs_left  = runs_dec;
                        upd.status     = gone ? pjt_pkg::ST_EXP : pjt_pkg::ST_WAIT;
                        emit           = 1'b1;
                        cand           = !gone;
                        cand_v         = {1'b0, ent_reg.period};
                    end
                    else if (ent_reg.status == pjt_pkg::ST_EXP)
                    begin
                        emit = 1'b1;
                    end
                    else if (ent_reg.status == pjt_pkg::ST_WAIT)
                    begin
                        cand   = 1'b1;
                        cand_v = t_reg[31] ? 32'd0 : t_reg;
                    end
                end
                res.kind            = fire ? pjt_pkg::KIND_FIRED : pjt_pkg::KIND_REMOVED;
                res.job_slot        = 4'(idx_reg);
                res.remaining_ms    = upd.time_left;
                res.job_status      = upd.status;
                res.iterations_left = upd.runs_left;
                res.expired_now     = gone;
                if (!emit || out_free)
                begin
                    push = emit;
                    if (used_reg[idx_reg] && ent_reg.status != pjt_pkg::ST_EXP)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = upd;
                    end
                    if (gone || (used_reg[idx_reg] && ent_reg.status == pjt_pkg::ST_EXP))
                    begin
                        used_next[idx_reg] = 1'b0;
                    end
                    if (cand && (!have_reg || cand_v < best_reg))
                    begin
                        best_next = cand_v;
                    end
                    if (cand)
                    begin
                        have_next = 1'b1;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_WAKE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        ram_re     = 1'b1;
                        ram_raddr  = idx_reg + 1'b1;
                        state_next = S_SUB;
                    end
                end
            end

            S_WAKE:
            begin
                res.kind         = pjt_pkg::KIND_WAKE;
                res.remaining_ms = best_reg;
                res.wake_valid   = have_reg;
                res.last         = 1'b1;
                if (out_free)
                begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_ONE:
            begin
                res.last = 1'b1;
                upd      = rd_ent;
                if (act_reg == pjt_pkg::ACT_CREATE)
                begin
                    if (free_found)
                    begin
                        upd.status    = pjt_pkg::ST_WAIT;
                        upd.time_left = '0;
                        upd.period    = ivl_reg;
                        upd.runs_left = cnt_reg;
                        res.kind      = pjt_pkg::KIND_REPLY;
                        res.job_slot  = 4'(free_idx);
                        ram_waddr     = free_idx;
                        ram_we        = out_free;
                        if (out_free)
                        begin
                            used_next[free_idx] = 1'b1;
                        end
                    end
                    else
                    begin
                        res.kind       = pjt_pkg::KIND_ERROR;
                        res.error_code = pjt_pkg::ERR_FULL;
                    end
                end
                else if (!slot_ok)
                begin
                    res.kind       = pjt_pkg::KIND_ERROR;
                    res.job_slot   = slot_reg;
                    res.error_code = pjt_pkg::ERR_EMPTY;
                end
                else
                begin
                    res.job_slot = slot_reg;
                    ram_waddr    = sidx;
                    case (act_reg)
                        pjt_pkg::ACT_REMOVE:
                        begin
                            res.kind = pjt_pkg::KIND_REMOVED;
                            if (out_free)
                            begin
                                used_next[sidx] = 1'b0;
                            end
                        end
                        pjt_pkg::ACT_SET_ST:
                        begin
                            res.kind   = pjt_pkg::KIND_REPLY;
                            upd.status = (ns_reg == pjt_pkg::ST_ALT) ? pjt_pkg::ST_WAIT
                                                                     : ns_reg;
                            ram_we     = out_free;
                        end
                        pjt_pkg::ACT_SET_IVL:
                        begin
                            res.kind   = pjt_pkg::KIND_REPLY;
                            upd.period = ivl_reg;
                            ram_we     = out_free;
                        end
                        pjt_pkg::ACT_SET_ITER:
                        begin
                            res.kind      = pjt_pkg::KIND_REPLY;
                            upd.runs_left = cnt_reg;
                            ram_we        = out_free;
                        end
                        default:
                        begin
                            res.kind = pjt_pkg::KIND_REPLY;
                        end
                    endcase
                end
                if (res.kind != pjt_pkg::KIND_ERROR)
                begin
                    res.remaining_ms    = upd.time_left;
                    res.job_status      = upd.status;
                    res.iterations_left = upd.runs_left;
                end
                ram_wdata = upd;
                if (out_free)
                begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            used_reg  <= '0;
            have_reg  <= 1'b0;
            best_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            used_reg  <= used_next;
            have_reg  <= have_next;
            best_reg  <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg   <= t_next;
        ent_reg <= ent_next;
        if (accept)
        begin
            act_reg   <= action;
            slot_reg  <= slot;
            delta_reg <= delta_ms;
            ivl_reg   <= interval_ms;
            cnt_reg   <= iteration_count;
            ns_reg    <= new_status;
        end
    end

    pjt_ram #(
        .WIDTH (pjt_pkg::ENTRY_W),
        .DEPTH (NUM_JOBS),
        .AW    (AW)
    ) u_job_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pjt_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .free      (out_free),
        .res_out   (res_q)
    );

    assign kind            = res_q.kind;
    assign job_slot        = res_q.job_slot;
    assign remaining_ms    = res_q.remaining_ms;
    assign job_status      = res_q.job_status;
    assign iterations_left = res_q.iterations_left;
    assign expired_now     = res_q.expired_now;
    assign wake_valid      = res_q.wake_valid;
    assign error_code      = res_q.error_code;
    assign last            = res_q.last;

    a_idle_used: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> (used_reg == $past(used_reg)))
        else $error("slot-used bits changed while idle");

    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_ONE || state_reg == S_UPD))
        else $error("RAM written outside an update step");

    a_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD && ram_re) |=>
            (state_reg == S_SUB && idx_reg == $past(idx_reg) + 1'b1))
        else $error("tick walk skipped a slot");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the periodic job timer table, with scoreboard and stimulus.
module testbench;

    localparam int NJ = pjt_pkg::NUM_JOBS_DEF;
    // Random requests after the directed opening, NOP requests not counted.
    localparam int RANDOM_REQUESTS = 360;
    // The last stretch of the run goes with no idling on either side.
    localparam int QUIET_FROM = 310;
    localparam int TICK_CYCLES = 2 * NJ + 2;
    localparam logic signed [63:0] MIN_MS = -64'sd2147483648;
    localparam logic [30:0] MAX_31 = 31'h7FFF_FFFF;

    // ------------------------------------------------------------------
    // Job table tracker: keeps its own copy of the job table, works out the
    // results each accepted request must produce, and checks the results
    // that come out of the block against them, oldest first.
    // ------------------------------------------------------------------
    class job_table_tracker;
        bit                 used [NJ];
        logic [1:0]         status [NJ];
        logic signed [31:0] left_ms [NJ];
        logic [30:0]        period_ms [NJ];
        logic [30:0]        runs [NJ];
        pjt_pkg::result_t   due_results [$];
        int                 mismatches;

        function void push(logic [2:0] k, logic [3:0] sl, logic signed [31:0] rem,
                           logic [1:0] st, logic [30:0] it, logic expn, logic wv,
                           logic [1:0] err);
            pjt_pkg::result_t r;
            r.kind            = k;
            r.job_slot        = sl;
            r.remaining_ms    = rem;
            r.job_status      = st;
            r.iterations_left = it;
            r.expired_now     = expn;
            r.wake_valid      = wv;
            r.error_code      = err;
            r.last            = 1'b0;
            due_results.push_back(r);
        endfunction

        function void push_entry(logic [2:0] k, int i, logic expn);
            push(k, 4'(i), left_ms[i], status[i], runs[i], expn, 1'b0, pjt_pkg::ERR_NONE);
        endfunction

        // Tick: age every running job (saturating), then fire / sweep in slot
        // order, then report the earliest wake among waiting jobs.
        function void run_tick(logic [30:0] delta);
            logic signed [63:0] aged;
            logic signed [31:0] best;
            logic signed [31:0] v;
            logic               gone;
            bit                 have;
            have = 0;
            best = 0;
            for (int i = 0; i < NJ; i++)
            begin
                if (used[i] && status[i] != pjt_pkg::ST_SUSP)
                begin
                    aged = 64'(left_ms[i]) - $signed({33'd0, delta});
                    if (aged < MIN_MS)
                        aged = MIN_MS;
                    left_ms[i] = aged[31:0];
                end
            end
            for (int i = 0; i < NJ; i++)
            begin
                if (!used[i])
                    continue;
                if (status[i] == pjt_pkg::ST_WAIT && left_ms[i] <= 0)
                begin
                    gone = 1'b0;
                    left_ms[i] = {1'b0, period_ms[i]};
                    if (runs[i] != 0)
                    begin
                        runs[i] = runs[i] - 31'd1;
                        if (runs[i] == 0)
                        begin
                            status[i] = pjt_pkg::ST_EXP;
                            gone = 1'b1;
                        end
                    end
                    push_entry(pjt_pkg::KIND_FIRED, i, gone);
                    if (gone)
                        used[i] = 0;
                end
                else if (status[i] == pjt_pkg::ST_EXP)
                begin
                    push_entry(pjt_pkg::KIND_REMOVED, i, 1'b0);
                    used[i] = 0;
                end
            end
            for (int i = 0; i < NJ; i++)
            begin
                if (used[i] && status[i] == pjt_pkg::ST_WAIT)
                begin
                    v = (left_ms[i] < 0) ? 32'sd0 : left_ms[i];
                    if (!have || v < best)
                        best = v;
                    have = 1;
                end
            end
            push(pjt_pkg::KIND_WAKE, 4'd0, best, pjt_pkg::ST_SUSP, 31'd0, 1'b0, have,
                 pjt_pkg::ERR_NONE);
        endfunction

        function void note_request(logic [2:0] act, logic [3:0] sl, logic [30:0] delta,
                                   logic [30:0] ivl, logic [30:0] cnt, logic [1:0] ns);
            int queued;
            int free_slot;
            queued = due_results.size();
            free_slot = -1;
            if (act == pjt_pkg::ACT_NOP)
                return;
            if (act == pjt_pkg::ACT_TICK)
            begin
                run_tick(delta);
            end
            else if (act == pjt_pkg::ACT_CREATE)
            begin
                for (int i = 0; i < NJ; i++)
                    if (free_slot < 0 && !used[i])
                        free_slot = i;
                if (free_slot < 0)
                begin
                    push(pjt_pkg::KIND_ERROR, 4'd0, 32'sd0, pjt_pkg::ST_SUSP, 31'd0, 1'b0,
                         1'b0, pjt_pkg::ERR_FULL);
                end
                else
                begin
                    used[free_slot]      = 1;
                    status[free_slot]    = pjt_pkg::ST_WAIT;
                    left_ms[free_slot]   = 32'sd0;
                    period_ms[free_slot] = ivl;
                    runs[free_slot]      = cnt;
                    push_entry(pjt_pkg::KIND_REPLY, free_slot, 1'b0);
                end
            end
            else if (!used[sl])
            begin
                push(pjt_pkg::KIND_ERROR, sl, 32'sd0, pjt_pkg::ST_SUSP, 31'd0, 1'b0, 1'b0,
                     pjt_pkg::ERR_EMPTY);
            end
            else if (act == pjt_pkg::ACT_REMOVE)
            begin
                push_entry(pjt_pkg::KIND_REMOVED, sl, 1'b0);
                used[sl] = 0;
            end
            else
            begin
                case (act)
                    pjt_pkg::ACT_SET_ST:
                        status[sl] = (ns == pjt_pkg::ST_ALT) ? pjt_pkg::ST_WAIT : ns;
                    pjt_pkg::ACT_SET_IVL:  period_ms[sl] = ivl;
                    pjt_pkg::ACT_SET_ITER: runs[sl] = cnt;
                    default: ;
                endcase
                push_entry(pjt_pkg::KIND_REPLY, sl, 1'b0);
            end
            if (due_results.size() > queued)
                due_results[due_results.size() - 1].last = 1'b1;
        endfunction

        function void compare_field(string name, logic signed [63:0] want,
                                    logic signed [63:0] seen);
            if (want !== seen)
            begin
                $error("%s: expected %0d, got %0d", name, want, seen);
                mismatches++;
            end
        endfunction

        function void check_result(pjt_pkg::result_t got);
            pjt_pkg::result_t want;
            if (due_results.size() == 0)
            begin
                $error("result with nothing pending: kind %0d slot %0d", got.kind,
                       got.job_slot);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            compare_field("kind", {61'd0, want.kind}, {61'd0, got.kind});
            compare_field("job_slot", {60'd0, want.job_slot}, {60'd0, got.job_slot});
            compare_field("remaining_ms", 64'(want.remaining_ms), 64'(got.remaining_ms));
            compare_field("job_status", {62'd0, want.job_status}, {62'd0, got.job_status});
            compare_field("iterations_left", {33'd0, want.iterations_left},
                          {33'd0, got.iterations_left});
            compare_field("expired_now", {63'd0, want.expired_now}, {63'd0, got.expired_now});
            compare_field("wake_valid", {63'd0, want.wake_valid}, {63'd0, got.wake_valid});
            compare_field("error_code", {62'd0, want.error_code}, {62'd0, got.error_code});
            compare_field("last", {63'd0, want.last}, {63'd0, got.last});
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         action;
    logic [3:0]         slot;
    logic [30:0]        delta_ms;
    logic [30:0]        interval_ms;
    logic [30:0]        iteration_count;
    logic [1:0]         new_status;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         kind;
    logic [3:0]         job_slot;
    logic signed [31:0] remaining_ms;
    logic [1:0]         job_status;
    logic [30:0]        iterations_left;
    logic               expired_now;
    logic               wake_valid;
    logic [1:0]         error_code;
    logic               last;

    job_table_tracker sb = new();

    // Shared run controls between the request driver and the result sink.
    bit quiet;          // no idling on either side from here on
    bit sender_gaps;    // request side inserts random gaps
    bit hold_off_req;   // asks the result side for one long stall

    periodic_job_timer_table #(.NUM_JOBS(NJ)) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .slot            (slot),
        .delta_ms        (delta_ms),
        .interval_ms     (interval_ms),
        .iteration_count (iteration_count),
        .new_status      (new_status),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .job_slot        (job_slot),
        .remaining_ms    (remaining_ms),
        .job_status      (job_status),
        .iterations_left (iterations_left),
        .expired_now     (expired_now),
        .wake_valid      (wake_valid),
        .error_code      (error_code),
        .last            (last)
    );

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Request driver helpers. All inputs change only by nonblocking
    // assignment at a rising edge. send_request lowers in_valid only through
    // sender_idle, so back-to-back requests keep valid high without a second
    // assignment in the same step; idle and drain lower it and always wait on the
    // clock before anything can raise it again.
    // ------------------------------------------------------------------
    task automatic sender_idle(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Sender pause: wait until the block has delivered everything owed.
    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic send_request(logic [2:0] act, logic [3:0] sl, logic [30:0] dl,
                                logic [30:0] iv, logic [30:0] ic, logic [1:0] ns);
        if (!quiet && sender_gaps && $urandom_range(0, 2) == 0)
            sender_idle($urandom_range(1, 19));
        action          <= act;
        slot            <= sl;
        delta_ms        <= dl;
        interval_ms     <= iv;
        iteration_count <= ic;
        new_status      <= ns;
        in_valid        <= 1'b1;
        // Values read here are the ones seen by the edge that just happened.
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(act, sl, dl, iv, ic, ns);
    endtask

    // Mostly aim at live slots so that edits and queries reach real jobs.
    function automatic logic [3:0] pick_slot();
        int live [$];
        for (int i = 0; i < NJ; i++)
            if (sb.used[i])
                live.push_back(i);
        if (live.size() != 0 && $urandom_range(0, 9) < 8)
            return 4'(live[$urandom_range(0, live.size() - 1)]);
        return 4'($urandom_range(0, NJ - 1));
    endfunction

    // Short periods keep jobs firing; a few huge ones exercise the wide path.
    function automatic logic [30:0] pick_interval();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            return 31'($urandom_range(0, 40));
        else if (sel == 7)
            return 31'($urandom);
        else if (sel == 8)
            return MAX_31;
        return 31'd0;
    endfunction

    function automatic logic [30:0] pick_count();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return 31'd0;
        else if (sel < 8)
            return 31'($urandom_range(1, 4));
        else if (sel == 8)
            return 31'($urandom);
        return MAX_31;
    endfunction

    function automatic logic [30:0] pick_delta();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 8)
            return 31'($urandom_range(0, 25));
        else if (sel == 8)
            return 31'($urandom);
        return MAX_31;
    endfunction

    task automatic random_request(output bit counted);
        logic [2:0] act;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 26)
            act = pjt_pkg::ACT_TICK;
        else if (pick < 44)
            act = pjt_pkg::ACT_CREATE;
        else if (pick < 56)
            act = pjt_pkg::ACT_SET_ST;
        else if (pick < 64)
            act = pjt_pkg::ACT_SET_IVL;
        else if (pick < 72)
            act = pjt_pkg::ACT_SET_ITER;
        else if (pick < 82)
            act = pjt_pkg::ACT_REMOVE;
        else if (pick < 97)
            act = pjt_pkg::ACT_QUERY;
        else
            act = pjt_pkg::ACT_NOP;
        send_request(act, pick_slot(), pick_delta(), pick_interval(), pick_count(),
                     2'($urandom_range(0, 3)));
        counted = (act != pjt_pkg::ACT_NOP);
    endtask

    // ------------------------------------------------------------------
    // Request stream: reset, directed opening, random body, wind-down.
    // ------------------------------------------------------------------
    initial
    begin
        int done;
        int loops;
        bit counted;

        rst_n           = 1'b0;
        in_valid        = 1'b0;
        out_stall       = 1'b0;
        action          = pjt_pkg::ACT_NOP;
        slot            = 4'd0;
        delta_ms        = 31'd0;
        interval_ms     = 31'd0;
        iteration_count = 31'd0;
        new_status      = pjt_pkg::ST_SUSP;
        quiet           = 1'b0;
        sender_gaps     = 1'b1;
        hold_off_req    = 1'b0;
        done            = 0;
        loops           = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: every slot request is an error, a tick has no wake.
        send_request(pjt_pkg::ACT_QUERY, 4'd0, 31'd0, 31'd0, 31'd0, pjt_pkg::ST_SUSP);
        send_request(pjt_pkg::ACT_SET_ITER, 4'd15, MAX_31, MAX_31, MAX_31, pjt_pkg::ST_EXP);
        send_request(pjt_pkg::ACT_TICK, 4'd0, 31'd0, 31'd0, 31'd0, pjt_pkg::ST_SUSP);

        // Slot 0 unlimited with max period, slot 1 one-shot with zero period,
        // slot 2 three runs, slot 3 huge run count.
        send_request(pjt_pkg::ACT_CREATE, 4'd9, 31'd0, MAX_31, 31'd0, pjt_pkg::ST_SUSP);
        send_request(pjt_pkg::ACT_CREATE, 4'd0, 31'd0, 31'd0, 31'd1, pjt_pkg::ST_SUSP);
        send_request(pjt_pkg::ACT_CREATE, 4'd0, 31'd0, 31'd5, 31'd3, pjt_pkg::ST_SUSP);
        send_request(pjt_pkg::ACT_CREATE, 4'd0, 31'd0, 31'd3, MAX_31, pjt_pkg::ST_SUSP);

        // New jobs are due at once: all fire, the one-shot expires.
        send_request(pjt_pkg::ACT_TICK, 4'd0, 31'd0, 31'd0, 31'd0, pjt_pkg::ST_SUSP);

        // Status code 3 reads as waiting; then suspend, expire, unlimit.
        send_request(pjt_pkg::ACT_SET_ST, 4'd2, 31'd0, 31'd0, 31'd0, pjt_pkg::ST_ALT);
        send_request(pjt_pkg::ACT_SET_ST, 4'd3, 31'd0, 31'd0, 31'd0, pjt_pkg::ST_SUSP);
        send_request(pjt_pkg::ACT_SET_ST, 4'd0, 31'd0, 31'd0, 31'd0, pjt_pkg::ST_EXP);
        send_request(pjt_pkg::ACT_SET_ITER, 4'd2, 31'd0, 31'd0, 31'd0, pjt_pkg::ST_SUSP);

        // Max elapsed time: expired slot swept, suspended slot left alone.
        send_request(pjt_pkg::ACT_TICK, 4'd0, MAX_31, 31'd0, 31'd0, pjt_pkg::ST_SUSP);
        send_request(pjt_pkg::ACT_QUERY, 4'd3, 31'd0, 31'd0, 31'd0, pjt_pkg::ST_SUSP);
        send_request(pjt_pkg::ACT_REMOVE, 4'd3, 31'd0, 31'd0, 31'd0, pjt_pkg::ST_SUSP);
        send_request(pjt_pkg::ACT_REMOVE, 4'd3, 31'd0, 31'd0, 31'd0, pjt_pkg::ST_SUSP);
        send_request(pjt_pkg::ACT_SET_IVL, 4'd1, 31'd0, MAX_31, 31'd0, pjt_pkg::ST_SUSP);
        send_request(pjt_pkg::ACT_NOP, 4'd6, MAX_31, MAX_31, MAX_31, pjt_pkg::ST_ALT);
        send_request(pjt_pkg::ACT_TICK, 4'd0, 31'd1, 31'd0, 31'd0, pjt_pkg::ST_SUSP);

        wait_all_results();

        // Long result-side hold while creates keep coming: the table fills,
        // a create hits the full error, and the input side backs up.
        hold_off_req = 1'b1;
        repeat (NJ + 1)
        begin
            send_request(pjt_pkg::ACT_CREATE, 4'($urandom), pick_delta(), pick_interval(),
                         pick_count(), 2'($urandom_range(0, 3)));
            done++;
        end

        while (done < RANDOM_REQUESTS)
        begin
            if (loops % 30 == 0)
                sender_gaps = $urandom_range(0, 1);
            if (done == RANDOM_REQUESTS / 2)
                wait_all_results();
            if (done >= QUIET_FROM)
                quiet = 1'b1;
            random_request(counted);
            if (counted)
                done++;
            loops++;
        end

        wait_all_results();
        // Let any stray result show up before judging the run.
        repeat (TICK_CYCLES + 8) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result sink: checks every accepted result and drives out_stall in
    // random bursts, plus one long hold when asked.
    // ------------------------------------------------------------------
    initial
    begin
        int               stall_left;
        int               free_left;
        pjt_pkg::result_t got;
        stall_left = 0;
        free_left  = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.kind            = kind;
                got.job_slot        = job_slot;
                got.remaining_ms    = remaining_ms;
                got.job_status      = job_status;
                got.iterations_left = iterations_left;
                got.expired_now     = expired_now;
                got.wake_valid      = wake_valid;
                got.error_code      = error_code;
                got.last            = last;
                sb.check_result(got);
            end
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left   = 300;
            end
            if (quiet)
            begin
                stall_left = 0;
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (free_left > 0)
            begin
                free_left--;
                out_stall <= 1'b0;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                // random free stretches give runs with no stall
                free_left = $urandom_range(1, 60) - 1;
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: a time limit far beyond the slowest legal run.
    initial
    begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
